// File: sv/keyboard_text_buffer_editor_macros.svh
// Assertion macros for the keyboard text buffer editor
`ifndef KEYBOARD_TEXT_BUFFER_EDITOR_MACROS_SVH
`define KEYBOARD_TEXT_BUFFER_EDITOR_MACROS_SVH
`ifndef SYNTHESIS
`define KTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kte assertion failed");
`define KTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kte assertion failed");
`else
`define KTE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KTE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/kte_pkg.sv
// Shared types, codes and key map for the keyboard text buffer editor
package kte_pkg;

  localparam int BUFFER_BYTES_DEF = 65536;
  localparam int VIEW_LINES_DEF   = 31;

  // command codes
  localparam logic [2:0] CMD_KEY_DOWN = 3'd0;
  localparam logic [2:0] CMD_KEY_UP   = 3'd1;
  localparam logic [2:0] CMD_CLOSE    = 3'd2;
  localparam logic [2:0] CMD_LOAD     = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;

  // key codes
  localparam logic [7:0] K_ESC      = 8'd1;
  localparam logic [7:0] K_BKSP     = 8'd14;
  localparam logic [7:0] K_TAB      = 8'd15;
  localparam logic [7:0] K_ENTER    = 8'd28;
  localparam logic [7:0] K_LCTRL    = 8'd29;
  localparam logic [7:0] K_S        = 8'd31;
  localparam logic [7:0] K_LSHIFT   = 8'd42;
  localparam logic [7:0] K_RSHIFT   = 8'd54;
  localparam logic [7:0] K_SPACE    = 8'd57;
  localparam logic [7:0] K_KPENTER  = 8'd96;
  localparam logic [7:0] K_RCTRL    = 8'd97;
  localparam logic [7:0] K_UP       = 8'd103;
  localparam logic [7:0] K_LEFT     = 8'd105;
  localparam logic [7:0] K_RIGHT    = 8'd106;
  localparam logic [7:0] K_DOWN     = 8'd108;
  localparam logic [7:0] MAP_SIZE   = 8'd54;
  localparam logic [5:0] MAP_LAST   = 6'd53;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // US layout, first character in the top byte; a blank means no character
  localparam logic [8*54-1:0] MAP_PLAIN =
    "  1234567890-=  qwertyuiop[]  asdfghjkl;'` \\zxcvbnm,./";
  localparam logic [8*54-1:0] MAP_SHIFT =
    "  !@#$%^&*()_+  QWERTYUIOP{}  ASDFGHJKL:\"~ |ZXCVBNM<>?";

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  key_code;
    logic [7:0]  load_data;
    logic [15:0] read_address;
  } item_t;

  typedef struct packed {
    logic [15:0] cursor_offset;
    logic [15:0] text_length;
    logic [15:0] top_line;
    logic        modified;
    logic        redraw;
    logic        caret_on;
    logic        save_request;
    logic        quit;
    logic [7:0]  read_data;
  } res_t;

  // printable byte for a key, zero when the key inserts nothing
  function automatic logic [7:0] key_char(input logic [7:0] code, input logic shift);
    logic [5:0] idx;
    logic [7:0] c;
    idx = '0;
    c   = '0;
    if (code == K_SPACE) begin
      c = CH_SPACE;
    end else if (code == K_TAB) begin
      c = CH_TAB;
    end else if (code < MAP_SIZE) begin
      idx = MAP_LAST - code[5:0];
      c   = shift ? MAP_SHIFT[idx*8 +: 8] : MAP_PLAIN[idx*8 +: 8];
      if (c == CH_SPACE) c = '0;
    end
    return c;
  endfunction

endpackage

// File: sv/kte_store.sv
// Text byte store: one write port, one registered read port
module kte_store #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/kte_seq.sv
// Editor sequencer: one pointer unit steps through the store a byte at a time
module kte_seq #(
  parameter int BUFFER_BYTES = kte_pkg::BUFFER_BYTES_DEF,
  parameter int VIEW_LINES   = kte_pkg::VIEW_LINES_DEF,
  parameter int AW           = $clog2(BUFFER_BYTES)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  kte_pkg::item_t item,
  input  logic           ack,
  output logic           idle,
  output logic           res_valid,
  output kte_pkg::res_t  res,
  output logic           mem_we,
  output logic [AW-1:0]  mem_waddr,
  output logic [7:0]     mem_wdata,
  output logic [AW-1:0]  mem_raddr,
  input  logic [7:0]     mem_rdata
);
  import kte_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_DISP   = 17'h00002,
    S_READ   = 17'h00004,
    S_INS_RD = 17'h00008,
    S_INS_WR = 17'h00010,
    S_DEL_RD = 17'h00020,
    S_DEL_WR = 17'h00040,
    S_SB_RD  = 17'h00080,
    S_SB_CHK = 17'h00100,
    S_SF_RD  = 17'h00200,
    S_SF_CHK = 17'h00400,
    S_NEXT   = 17'h00800,
    S_FL_RD  = 17'h01000,
    S_FL_CHK = 17'h02000,
    S_FL_FIN = 17'h04000,
    S_FIN    = 17'h08000,
    S_DONE   = 17'h10000
  } state_t;

  typedef enum logic [4:0] {
    PH_UP1 = 5'b00001,
    PH_UP2 = 5'b00010,
    PH_DN1 = 5'b00100,
    PH_DN2 = 5'b01000,
    PH_DN3 = 5'b10000
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  item_t  item_r, item_nxt;
  logic [AW-1:0] cur_r, cur_nxt, len_r, len_nxt, top_r, top_nxt;
  logic [AW-1:0] p_r, p_nxt, e_r, e_nxt, col_r, col_nxt, line_r, line_nxt;
  logic          mod_r, mod_nxt, shift_r, shift_nxt, ctrl_r, ctrl_nxt, stop_r, stop_nxt;
  logic [4:0]    tick_r, tick_nxt;
  logic [7:0]    ch_r, ch_nxt, rd_r, rd_nxt;
  logic          view_r, view_nxt, save_r, save_nxt, quit_r, quit_nxt;
  logic          redraw_r, redraw_nxt;
  logic          full;
  logic [7:0]    kc;
  logic [AW-1:0] span;
  logic [4:0]    tick_inc;

  assign full     = (32'(len_r) + 32'd1) >= 32'(BUFFER_BYTES);
  assign kc       = key_char(item_r.key_code, shift_r);
  assign tick_inc = tick_r + 5'd1;
  assign span     = (phase_r == PH_UP2) ? (e_r - p_r) : (p_r - e_r);

  always_comb begin
    state_nxt = state_r;  phase_nxt = phase_r;  item_nxt = item_r;
    cur_nxt = cur_r;  len_nxt = len_r;  top_nxt = top_r;
    p_nxt = p_r;  e_nxt = e_r;  col_nxt = col_r;  line_nxt = line_r;
    mod_nxt = mod_r;  shift_nxt = shift_r;  ctrl_nxt = ctrl_r;  stop_nxt = stop_r;
    tick_nxt = tick_r;  ch_nxt = ch_r;  rd_nxt = rd_r;
    view_nxt = view_r;  save_nxt = save_r;  quit_nxt = quit_r;  redraw_nxt = redraw_r;
    mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;  mem_raddr = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = item;
          view_nxt = 1'b0;  save_nxt = 1'b0;  quit_nxt = 1'b0;
          redraw_nxt = 1'b0;  rd_nxt = '0;
          state_nxt = S_DISP;
        end
      end
      // decode the command
      S_DISP: begin
        state_nxt = S_DONE;
        if (item_r.cmd == CMD_LOAD) begin
          if (!full) begin
            mem_we = 1'b1;  mem_waddr = len_r;  mem_wdata = item_r.load_data;
            len_nxt = len_r + 1'b1;
          end
          cur_nxt = '0;  top_nxt = '0;  mod_nxt = 1'b0;  redraw_nxt = 1'b1;
        end else if (item_r.cmd == CMD_READ) begin
          if (32'(item_r.read_address) < 32'(len_r)) begin
            mem_raddr = AW'(item_r.read_address);
            state_nxt = S_READ;
          end
        end else if (!stop_r && item_r.cmd == CMD_KEY_UP) begin
          if (item_r.key_code == K_LSHIFT || item_r.key_code == K_RSHIFT) shift_nxt = 1'b0;
          if (item_r.key_code == K_LCTRL || item_r.key_code == K_RCTRL) ctrl_nxt = 1'b0;
          state_nxt = S_FIN;
        end else if (!stop_r && item_r.cmd == CMD_CLOSE) begin
          quit_nxt = 1'b1;  state_nxt = S_FIN;
        end else if (!stop_r && item_r.cmd == CMD_KEY_DOWN) begin
          state_nxt = S_FIN;
          if (item_r.key_code == K_LSHIFT || item_r.key_code == K_RSHIFT) begin
            shift_nxt = 1'b1;
          end else if (item_r.key_code == K_LCTRL || item_r.key_code == K_RCTRL) begin
            ctrl_nxt = 1'b1;
          end else if (item_r.key_code == K_ESC) begin
            quit_nxt = 1'b1;
          end else if (item_r.key_code == K_BKSP) begin
            view_nxt = 1'b1;
            if (cur_r == '0) begin
              p_nxt = '0;  line_nxt = '0;  state_nxt = S_FL_RD;
            end else begin
              p_nxt = cur_r;  state_nxt = S_DEL_RD;
            end
          end else if (item_r.key_code == K_ENTER || item_r.key_code == K_KPENTER) begin
            view_nxt = 1'b1;  ch_nxt = CH_NL;
            if (full) begin
              p_nxt = '0;  line_nxt = '0;  state_nxt = S_FL_RD;
            end else begin
              p_nxt = len_r;  state_nxt = S_INS_RD;
            end
          end else if (item_r.key_code == K_UP) begin
            view_nxt = 1'b1;  phase_nxt = PH_UP1;  p_nxt = cur_r;  state_nxt = S_SB_RD;
          end else if (item_r.key_code == K_DOWN) begin
            view_nxt = 1'b1;  phase_nxt = PH_DN1;  p_nxt = cur_r;  state_nxt = S_SB_RD;
          end else if (item_r.key_code == K_LEFT) begin
            view_nxt = 1'b1;
            if (cur_r != '0) cur_nxt = cur_r - 1'b1;
            p_nxt = '0;  line_nxt = '0;  state_nxt = S_FL_RD;
          end else if (item_r.key_code == K_RIGHT) begin
            view_nxt = 1'b1;
            if (cur_r < len_r) cur_nxt = cur_r + 1'b1;
            p_nxt = '0;  line_nxt = '0;  state_nxt = S_FL_RD;
          end else if (item_r.key_code == K_S && ctrl_r) begin
            save_nxt = 1'b1;  mod_nxt = 1'b0;  view_nxt = 1'b1;
          end else if (kc != '0) begin
            view_nxt = 1'b1;  ch_nxt = kc;
            if (full) begin
              p_nxt = '0;  line_nxt = '0;  state_nxt = S_FL_RD;
            end else begin
              p_nxt = len_r;  state_nxt = S_INS_RD;
            end
          end
        end
      end
      S_READ: begin
        rd_nxt = mem_rdata;  state_nxt = S_DONE;
      end
      // insert: move the tail up one byte, top end first
      S_INS_RD: begin
        if (p_r == cur_r) begin
          mem_we = 1'b1;  mem_waddr = cur_r;  mem_wdata = ch_r;
          cur_nxt = cur_r + 1'b1;  len_nxt = len_r + 1'b1;  mod_nxt = 1'b1;
          p_nxt = '0;  line_nxt = '0;  state_nxt = S_FL_RD;
        end else begin
          mem_raddr = p_r - 1'b1;  state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mem_we = 1'b1;  mem_waddr = p_r;  mem_wdata = mem_rdata;
        p_nxt = p_r - 1'b1;  state_nxt = S_INS_RD;
      end
      // backspace: move the tail down one byte
      S_DEL_RD: begin
        if (p_r == len_r) begin
          cur_nxt = cur_r - 1'b1;  len_nxt = len_r - 1'b1;  mod_nxt = 1'b1;
          p_nxt = '0;  line_nxt = '0;  state_nxt = S_FL_RD;
        end else begin
          mem_raddr = p_r;  state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        mem_we = 1'b1;  mem_waddr = p_r - 1'b1;  mem_wdata = mem_rdata;
        p_nxt = p_r + 1'b1;  state_nxt = S_DEL_RD;
      end
      // scan back to line start
      S_SB_RD: begin
        if (p_r == '0) begin
          state_nxt = S_NEXT;
        end else begin
          mem_raddr = p_r - 1'b1;  state_nxt = S_SB_CHK;
        end
      end
      S_SB_CHK: begin
        if (mem_rdata == CH_NL) state_nxt = S_NEXT;
        else begin
          p_nxt = p_r - 1'b1;  state_nxt = S_SB_RD;
        end
      end
      // scan forward to line end
      S_SF_RD: begin
        if (p_r >= len_r) begin
          state_nxt = S_NEXT;
        end else begin
          mem_raddr = p_r;  state_nxt = S_SF_CHK;
        end
      end
      S_SF_CHK: begin
        if (mem_rdata == CH_NL) state_nxt = S_NEXT;
        else begin
          p_nxt = p_r + 1'b1;  state_nxt = S_SF_RD;
        end
      end
      // vertical move steps
      S_NEXT: begin
        case (phase_r)
          PH_UP1: begin
            if (p_r == '0) begin
              p_nxt = '0;  line_nxt = '0;  state_nxt = S_FL_RD;
            end else begin
              col_nxt = cur_r - p_r;  e_nxt = p_r - 1'b1;  p_nxt = p_r - 1'b1;
              phase_nxt = PH_UP2;  state_nxt = S_SB_RD;
            end
          end
          PH_DN1: begin
            col_nxt = cur_r - p_r;  p_nxt = cur_r;
            phase_nxt = PH_DN2;  state_nxt = S_SF_RD;
          end
          PH_DN2: begin
            if (p_r >= len_r) begin
              p_nxt = '0;  line_nxt = '0;  state_nxt = S_FL_RD;
            end else begin
              e_nxt = p_r + 1'b1;  p_nxt = p_r + 1'b1;
              phase_nxt = PH_DN3;  state_nxt = S_SF_RD;
            end
          end
          default: begin
            // land on the target line, column clamped to its length
            if (phase_r == PH_UP2) cur_nxt = p_r + ((col_r < span) ? col_r : span);
            else                   cur_nxt = e_r + ((col_r < span) ? col_r : span);
            p_nxt = '0;  line_nxt = '0;  state_nxt = S_FL_RD;
          end
        endcase
      end
      // count line breaks before the cursor
      S_FL_RD: begin
        if (p_r == cur_r) begin
          state_nxt = S_FL_FIN;
        end else begin
          mem_raddr = p_r;  state_nxt = S_FL_CHK;
        end
      end
      S_FL_CHK: begin
        if (mem_rdata == CH_NL) line_nxt = line_r + 1'b1;
        p_nxt = p_r + 1'b1;  state_nxt = S_FL_RD;
      end
      S_FL_FIN: begin
        if (line_r < top_r) top_nxt = line_r;
        else if (32'(line_r) >= 32'(top_r) + 32'(VIEW_LINES))
          top_nxt = AW'(32'(line_r) - 32'(VIEW_LINES) + 32'd1);
        state_nxt = S_FIN;
      end
      // tick and redraw for key events; a close or escape stops editing instead
      S_FIN: begin
        if (quit_r) begin
          stop_nxt = 1'b1;
        end else begin
          tick_nxt = tick_inc;
          redraw_nxt = view_r || (tick_inc[3:0] == 4'd0);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (ack) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r <= '0;  len_r <= '0;  top_r <= '0;
      mod_r <= 1'b0;  shift_r <= 1'b0;  ctrl_r <= 1'b0;  stop_r <= 1'b0;
      tick_r <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r <= cur_nxt;  len_r <= len_nxt;  top_r <= top_nxt;
      mod_r <= mod_nxt;  shift_r <= shift_nxt;  ctrl_r <= ctrl_nxt;  stop_r <= stop_nxt;
      tick_r <= tick_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;  item_r <= item_nxt;
    p_r <= p_nxt;  e_r <= e_nxt;  col_r <= col_nxt;  line_r <= line_nxt;
    ch_r <= ch_nxt;  rd_r <= rd_nxt;
    view_r <= view_nxt;  save_r <= save_nxt;  quit_r <= quit_nxt;  redraw_r <= redraw_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.cursor_offset = 16'(cur_r);
    res.text_length   = 16'(len_r);
    res.top_line      = 16'(top_r);
    res.modified      = mod_r;
    res.redraw        = redraw_r;
    res.caret_on      = !tick_r[4];
    res.save_request  = save_r;
    res.quit          = stop_r;
    res.read_data     = rd_r;
  end
endmodule

// File: sv/keyboard_text_buffer_editor.sv
// Keyboard text buffer editor top level: handshakes, result register, store
// One word is taken at a time. Reads, loads and modifier keys finish without
// walking the store; an edit or arrow key walks the text store a byte at a time
// through its single read port, so an insert or backspace moves the tail
// between the cursor and the end of the text and then counts line breaks from
// the start to the cursor, and up/down also scans the lines it crosses. A
// result waits in the output register while the next word is already taken.
// The store needs no clearing after reset.
`include "keyboard_text_buffer_editor_macros.svh"
module keyboard_text_buffer_editor #(
  parameter int BUFFER_BYTES = kte_pkg::BUFFER_BYTES_DEF,
  parameter int VIEW_LINES   = kte_pkg::VIEW_LINES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_key_code,
  input  logic [7:0]  in_load_data,
  input  logic [15:0] in_read_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_cursor_offset,
  output logic [15:0] out_text_length,
  output logic [15:0] out_top_line,
  output logic        out_modified,
  output logic        out_redraw,
  output logic        out_caret_on,
  output logic        out_save_request,
  output logic        out_quit,
  output logic [7:0]  out_read_data
);
  import kte_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);

  item_t         item;
  res_t          res, res_r;
  logic          start, idle, res_valid, take, out_valid_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  assign item.cmd          = in_cmd;
  assign item.key_code     = in_key_code;
  assign item.load_data    = in_load_data;
  assign item.read_address = in_read_address;

  assign in_ready = idle;
  assign start    = in_valid && in_ready;
  assign take     = res_valid && (!out_valid_r || out_ready);

  kte_seq #(
    .BUFFER_BYTES(BUFFER_BYTES), .VIEW_LINES(VIEW_LINES), .AW(AW)
  ) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .item(item), .ack(take),
    .idle(idle), .res_valid(res_valid), .res(res),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr), .mem_rdata(mem_rdata)
  );

  kte_store #(.AW(AW)) u_store (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_offset = res_r.cursor_offset;
  assign out_text_length   = res_r.text_length;
  assign out_top_line      = res_r.top_line;
  assign out_modified      = res_r.modified;
  assign out_redraw        = res_r.redraw;
  assign out_caret_on      = res_r.caret_on;
  assign out_save_request  = res_r.save_request;
  assign out_quit          = res_r.quit;
  assign out_read_data     = res_r.read_data;

  // a taken word keeps the sequencer busy on the next cycle
  `KTE_ASSERT_NEXT(a_busy_after_take, clk, rst_n, start, !in_ready)
  // a finished result always lands in the output register
  `KTE_ASSERT_NEXT(a_result_lands, clk, rst_n, take, out_valid)
  // the sequencer never takes a word while a result is pending inside it
  `KTE_ASSERT_NOW(a_no_overlap, clk, rst_n, res_valid, !in_ready)
endmodule

// File: tb/keyboard_text_buffer_editor_tb.sv
// Self-checking testbench for the keyboard text buffer editor
module keyboard_text_buffer_editor_tb;
  import kte_pkg::*;

  localparam int STORE_BYTES = BUFFER_BYTES_DEF;
  localparam int VIEW_ROWS   = VIEW_LINES_DEF;
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_cmd = '0;
  logic [7:0]  in_key_code = '0;
  logic [7:0]  in_load_data = '0;
  logic [15:0] in_read_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_cursor_offset;
  logic [15:0] out_text_length;
  logic [15:0] out_top_line;
  logic        out_modified;
  logic        out_redraw;
  logic        out_caret_on;
  logic        out_save_request;
  logic        out_quit;
  logic [7:0]  out_read_data;

  keyboard_text_buffer_editor dut (.*);

  always #5 clk = ~clk;

  // editor state as predicted
  logic [7:0]  text_mem [STORE_BYTES];
  int unsigned text_len, caret, first_line;
  logic        dirty, shift_dn, ctrl_dn, halted;
  logic [4:0]  tick;

  item_t pending_words[$];
  res_t  expected_results[$];
  int    tx_idle_pct = 38;
  int    rx_idle_pct = 61;
  int    results_seen = 0;
  int    errors = 0;
  int    quiet_cycles = 0;
  logic  in_took = 1'b0;

  function automatic int unsigned line_start(int unsigned off);
    while (off > 0 && text_mem[off - 1] != CH_NL) off--;
    return off;
  endfunction

  function automatic int unsigned line_stop(int unsigned off);
    while (off < text_len && text_mem[off] != CH_NL) off++;
    return off;
  endfunction

  function automatic void put_char(logic [7:0] c);
    if (text_len + 1 >= STORE_BYTES) return;
    for (int unsigned i = text_len; i > caret; i--) text_mem[i] = text_mem[i - 1];
    text_mem[caret] = c;
    caret++;
    text_len++;
    dirty = 1'b1;
  endfunction

  function automatic void delete_back();
    if (caret == 0) return;
    for (int unsigned i = caret - 1; i + 1 < text_len; i++) text_mem[i] = text_mem[i + 1];
    caret--;
    text_len--;
    dirty = 1'b1;
  endfunction

  // keep the caret line inside the window
  function automatic void scroll_to_caret();
    int unsigned row;
    row = 0;
    for (int unsigned i = 0; i < caret; i++) if (text_mem[i] == CH_NL) row++;
    if (row < first_line) first_line = row;
    if (row >= first_line + VIEW_ROWS) first_line = row - VIEW_ROWS + 1;
  endfunction

  function automatic void caret_up();
    int unsigned ls, col, pe, ps;
    ls = line_start(caret);
    if (ls == 0) return;
    col = caret - ls;
    pe = ls - 1;
    ps = line_start(pe);
    caret = ps + ((col < pe - ps) ? col : pe - ps);
  endfunction

  function automatic void caret_down();
    int unsigned ls, le, col, ns, nlen;
    ls = line_start(caret);
    le = line_stop(caret);
    if (le >= text_len) return;
    col = caret - ls;
    ns = le + 1;
    nlen = line_stop(ns) - ns;
    caret = ns + ((col < nlen) ? col : nlen);
  endfunction

  function automatic logic [7:0] typed_char(logic [7:0] code);
    logic [7:0] c;
    if (code == K_SPACE) return CH_SPACE;
    if (code == K_TAB) return CH_TAB;
    if (code >= MAP_SIZE) return '0;
    c = shift_dn ? MAP_SHIFT[(53 - code) * 8 +: 8] : MAP_PLAIN[(53 - code) * 8 +: 8];
    return (c == CH_SPACE) ? 8'h00 : c;
  endfunction

  // one command in, one predicted result out
  function automatic res_t predict_edit(item_t w);
    res_t r;
    logic view, stop_now;
    logic [7:0] c;
    r = '0;
    view = 1'b0;
    stop_now = 1'b0;
    if (w.cmd == CMD_LOAD) begin
      if (text_len + 1 < STORE_BYTES) begin
        text_mem[text_len] = w.load_data;
        text_len++;
      end
      caret = 0;
      first_line = 0;
      dirty = 1'b0;
      r.redraw = 1'b1;
    end else if (w.cmd == CMD_READ) begin
      if (w.read_address < text_len) r.read_data = text_mem[w.read_address];
    end else if (w.cmd <= CMD_CLOSE && !halted) begin
      if (w.cmd == CMD_KEY_DOWN) begin
        case (w.key_code)
          K_LSHIFT, K_RSHIFT: shift_dn = 1'b1;
          K_LCTRL, K_RCTRL: ctrl_dn = 1'b1;
          K_ESC: stop_now = 1'b1;
          K_BKSP: begin
            delete_back(); scroll_to_caret(); view = 1'b1;
          end
          K_ENTER, K_KPENTER: begin
            put_char(CH_NL); scroll_to_caret(); view = 1'b1;
          end
          K_UP: begin
            caret_up(); scroll_to_caret(); view = 1'b1;
          end
          K_DOWN: begin
            caret_down(); scroll_to_caret(); view = 1'b1;
          end
          K_LEFT: begin
            if (caret > 0) caret--;
            scroll_to_caret(); view = 1'b1;
          end
          K_RIGHT: begin
            if (caret < text_len) caret++;
            scroll_to_caret(); view = 1'b1;
          end
          default: begin
            if (w.key_code == K_S && ctrl_dn) begin
              r.save_request = 1'b1;
              dirty = 1'b0;
              view = 1'b1;
            end else begin
              c = typed_char(w.key_code);
              if (c != 0) begin
                put_char(c); scroll_to_caret(); view = 1'b1;
              end
            end
          end
        endcase
      end else if (w.cmd == CMD_KEY_UP) begin
        if (w.key_code == K_LSHIFT || w.key_code == K_RSHIFT) shift_dn = 1'b0;
        if (w.key_code == K_LCTRL || w.key_code == K_RCTRL) ctrl_dn = 1'b0;
      end else begin
        stop_now = 1'b1;
      end
      if (stop_now) begin
        halted = 1'b1;
      end else begin
        tick = tick + 1'b1;
        r.redraw = view || (tick[3:0] == 0);
      end
    end
    r.cursor_offset = caret[15:0];
    r.text_length = text_len[15:0];
    r.top_line = first_line[15:0];
    r.modified = dirty;
    r.caret_on = ~tick[4];
    r.quit = halted;
    return r;
  endfunction

  task automatic push_word(logic [2:0] cmd, logic [7:0] code, logic [7:0] ld = '0,
                           logic [15:0] ra = '0);
    item_t w;
    w.cmd = cmd;
    w.key_code = code;
    w.load_data = ld;
    w.read_address = ra;
    pending_words.push_back(w);
  endtask

  task automatic press(logic [7:0] code);
    push_word(CMD_KEY_DOWN, code, 8'($urandom), 16'($urandom));
  endtask

  // mostly well-formed typing, plus noise
  task automatic push_random_burst();
    int pick;
    logic [7:0] code;
    pick = $urandom_range(99);
    if (pick < 35) begin
      do code = 8'($urandom_range(2, 53)); while (code == K_LCTRL || code == K_LSHIFT ||
                                               code == K_BKSP || code == K_ENTER);
      press(code);
    end else if (pick < 55) begin
      press($urandom_range(1) ? K_ENTER : K_KPENTER);
    end else if (pick < 68) begin
      case ($urandom_range(3))
        0: press(K_UP);
        1: press(K_DOWN);
        2: press(K_LEFT);
        default: press(K_RIGHT);
      endcase
    end else if (pick < 74) begin
      press(K_BKSP);
    end else if (pick < 78) begin
      code = $urandom_range(1) ? K_LSHIFT : K_RSHIFT;
      press(code);
      press(8'($urandom_range(2, 53)));
      push_word(CMD_KEY_UP, code);
    end else if (pick < 81) begin
      code = $urandom_range(1) ? K_LCTRL : K_RCTRL;
      press(code);
      press(K_S);
      push_word(CMD_KEY_UP, code);
    end else if (pick < 84) begin
      push_word(CMD_LOAD, 8'($urandom), 8'($urandom), 16'($urandom));
    end else if (pick < 92) begin
      push_word(CMD_READ, 8'($urandom), 8'($urandom),
                $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 200)));
    end else if (pick < 96) begin
      do code = 8'($urandom); while (code == K_ESC);
      press(code);
    end else if (pick < 98) begin
      push_word(CMD_KEY_UP, 8'($urandom));
    end else begin
      push_word(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // input driver
  always @(negedge clk) begin
    item_t w;
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_cmd <= w.cmd;
        in_key_code <= w.key_code;
        in_load_data <= w.load_data;
        in_read_address <= w.read_address;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off early on
  always @(negedge clk) begin
    int hold_left;
    logic held_once;
    if (!rst_n) begin
      hold_left = 0;
      held_once = 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!held_once && results_seen >= 15) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // predict on accepted words, check accepted results
  always @(posedge clk) begin
    res_t e;
    in_took <= in_valid && in_ready;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_valid && in_ready)
        expected_results.push_back(predict_edit({in_cmd, in_key_code, in_load_data,
                                                 in_read_address}));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("cursor_offset", e.cursor_offset, out_cursor_offset);
          check_field("text_length", e.text_length, out_text_length);
          check_field("top_line", e.top_line, out_top_line);
          check_field("modified", e.modified, out_modified);
          check_field("redraw", e.redraw, out_redraw);
          check_field("caret_on", e.caret_on, out_caret_on);
          check_field("save_request", e.save_request, out_save_request);
          check_field("quit", e.quit, out_quit);
          check_field("read_data", e.read_data, out_read_data);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    foreach (text_mem[i]) text_mem[i] = '0;
    text_len = 0; caret = 0; first_line = 0;
    dirty = 0; shift_dn = 0; ctrl_dn = 0; halted = 0; tick = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-buffer edges, each key class but escape, odd commands
    push_word(CMD_READ, 8'hFF, 8'hFF, 16'h0000);
    push_word(CMD_READ, 8'h00, 8'h00, 16'hFFFF);
    press(K_BKSP);
    press(K_LEFT);
    press(K_RIGHT);
    press(K_UP);
    press(K_DOWN);
    press(8'd2);
    press(K_LSHIFT);
    press(8'd16);
    press(8'd53);
    push_word(CMD_KEY_UP, K_LSHIFT);
    press(K_SPACE);
    press(K_TAB);
    press(K_ENTER);
    press(K_KPENTER);
    press(K_UP);
    press(K_LCTRL);
    press(K_S);
    push_word(CMD_KEY_UP, K_LCTRL);
    press(8'd255);
    push_word(3'd5, 8'hAA, 8'h55, 16'hA5A5);
    push_word(3'd7, 8'h55, 8'hAA, 16'h5A5A);
    push_word(CMD_LOAD, 8'h00, 8'hFF);
    push_word(CMD_READ, 8'h00, 8'h00, 16'd1);

    repeat (25) push_random_burst();
    drain();
    tx_idle_pct = 61;
    rx_idle_pct = 38;
    repeat (25) push_random_burst();
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (20) push_random_burst();

    // closing: close ends editing, later keys are dropped, load/read still work
    push_word(CMD_CLOSE, 8'h00);
    press(K_ESC);
    press(8'd30);
    push_word(CMD_KEY_UP, K_LSHIFT);
    push_word(CMD_LOAD, 8'h00, 8'h41);
    push_word(CMD_READ, 8'h00, 8'h00, 16'd0);
    drain();

    while (expected_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/kte_pkg.sv
sv/kte_store.sv
sv/kte_seq.sv
sv/keyboard_text_buffer_editor.sv
tb/keyboard_text_buffer_editor_tb.sv
